// ----- hdl/sglr_pkg.sv -----
`timescale 1ns / 1ps

package sglr_pkg;

  // Default width of a sequence number.
  localparam int SEQ_WIDTH_DEFAULT = 16;

  // Receipt and miss counters saturate at the top of their range.
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // The ratio is given in hundredths of a percent.
  localparam int RATIO_W = 14;
  localparam logic [RATIO_W-1:0] RATIO_SCALE = RATIO_W'(10000);

  // Widths of the divider operands. The divisor is the sum of both counters.
  // The numerator is the miss count times the scale.
  localparam int DEN_W  = COUNT_W + 1;
  localparam int PROD_W = COUNT_W + RATIO_W;

  // The quotient never exceeds the scale, so it has RATIO_W bits and needs
  // one restoring step for each of them.
  localparam int DIV_STEPS = RATIO_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // How one sequence number was classified.
  typedef enum logic [1:0] {
    OUT_FIRST     = 2'd0,
    OUT_NEWER     = 2'd1,
    OUT_DUPLICATE = 2'd2,
    OUT_ORDER     = 2'd3
  } outcome_t;

endpackage

// ----- hdl/sequence_gap_loss_ratio.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in        to block   in_valid, in_stall   seq_number
// out       from block out_valid, out_stall loss_ratio, missed_count, received_count,
//                                           first_seq, outcome
//
// Each item passes through the sequencer states in order: idle takes it, update
// classifies it and updates the counters, mul does the multiply by 10000, div runs
// 14 steps of the shared restoring subtract and compare unit, and finish loads
// the output register. A new item is taken only once the last has been loaded.
// Reset (rst, synchronous) forgets the first packet and clears both counters.
// A result waits in the output register while out_stall is high; the next item
// is still taken meanwhile and only its final load waits for the register.

module sequence_gap_loss_ratio #(
  parameter int SEQ_WIDTH = sglr_pkg::SEQ_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [SEQ_WIDTH-1:0]         seq_number,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sglr_pkg::RATIO_W-1:0] loss_ratio,
  output logic [sglr_pkg::COUNT_W-1:0] missed_count,
  output logic [sglr_pkg::COUNT_W-1:0] received_count,
  output logic [SEQ_WIDTH-1:0]         first_seq,
  output sglr_pkg::outcome_t           outcome
);

  // The gap sum needs room for whichever is wider, the gap or the counter,
  // plus one carry bit so that saturation can be detected.
  localparam int SUM_W =
    ((SEQ_WIDTH > sglr_pkg::COUNT_W) ? SEQ_WIDTH : sglr_pkg::COUNT_W) + 1;

  // One-hot sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPDATE = 5'b00010,
    ST_MUL    = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;

  // Tracking state kept across packets.
  logic                         seen_first;
  logic [SEQ_WIDTH-1:0]         last_seq;
  logic [SEQ_WIDTH-1:0]         first_seq_reg;
  logic [sglr_pkg::COUNT_W-1:0] missed_total;
  logic [sglr_pkg::COUNT_W-1:0] received_total;

  // Working registers for the item in flight.
  logic [SEQ_WIDTH-1:0]         seq_hold;
  sglr_pkg::outcome_t           outcome_hold;
  logic [sglr_pkg::PROD_W-1:0]  rem;
  logic [sglr_pkg::PROD_W-1:0]  dsh;
  logic [sglr_pkg::RATIO_W-1:0] quot;
  logic [sglr_pkg::STEP_W-1:0]  step_cnt;

  // Classification and counter updates, used in the update state.
  logic [SEQ_WIDTH-1:0]         gap;
  logic [SUM_W-1:0]             gap_sum;
  logic [sglr_pkg::COUNT_W-1:0] missed_next;
  logic [sglr_pkg::COUNT_W-1:0] received_next;

  // The shared divider step and the operands that the multiply state loads.
  logic [sglr_pkg::PROD_W:0]    diff;
  logic                         fits;
  logic [sglr_pkg::DEN_W-1:0]   den;
  logic                         load_out;

  // The block takes a new sequence number only when its sequencer is idle.
  assign in_stall = (state != ST_IDLE);

  // A newer packet adds the numbers skipped since the last one, saturating.
  always_comb begin
    gap     = seq_hold - last_seq - SEQ_WIDTH'(1);
    gap_sum = SUM_W'(missed_total) + SUM_W'(gap);
    if (gap_sum > SUM_W'(sglr_pkg::COUNT_MAX)) begin
      missed_next = sglr_pkg::COUNT_MAX;
    end else begin
      missed_next = gap_sum[sglr_pkg::COUNT_W-1:0];
    end
    if (received_total == sglr_pkg::COUNT_MAX) begin
      received_next = received_total;
    end else begin
      received_next = received_total + sglr_pkg::COUNT_W'(1);
    end
  end

  // One restoring step: subtract the shifted divisor if it fits.
  always_comb begin
    diff = {1'b0, rem} - {1'b0, dsh};
    fits = ~diff[sglr_pkg::PROD_W];
    den  = sglr_pkg::DEN_W'(received_total) + sglr_pkg::DEN_W'(missed_total);
  end

  // The finished result moves into the output register once it is free or
  // is being taken in this cycle.
  assign load_out = (state == ST_FINISH) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      seen_first     <= 1'b0;
      last_seq       <= '0;
      first_seq_reg  <= '0;
      missed_total   <= '0;
      received_total <= '0;
      step_cnt       <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            seq_hold <= seq_number;
            state    <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          // Classify the packet against the last in-order number.
          if (!seen_first) begin
            seen_first     <= 1'b1;
            first_seq_reg  <= seq_hold;
            last_seq       <= seq_hold;
            received_total <= received_next;
            outcome_hold   <= sglr_pkg::OUT_FIRST;
          end else if (seq_hold > last_seq) begin
            missed_total   <= missed_next;
            last_seq       <= seq_hold;
            received_total <= received_next;
            outcome_hold   <= sglr_pkg::OUT_NEWER;
          end else if (seq_hold == last_seq) begin
            outcome_hold   <= sglr_pkg::OUT_DUPLICATE;
          end else begin
            outcome_hold   <= sglr_pkg::OUT_ORDER;
          end
          state <= ST_MUL;
        end
        ST_MUL: begin
          // The divisor starts aligned with the top quotient bit.
          rem      <= sglr_pkg::PROD_W'(missed_total) *
                      sglr_pkg::PROD_W'(sglr_pkg::RATIO_SCALE);
          dsh      <= sglr_pkg::PROD_W'(den) << (sglr_pkg::DIV_STEPS - 1);
          step_cnt <= '0;
          state    <= ST_DIV;
        end
        ST_DIV: begin
          if (fits) begin
            rem <= diff[sglr_pkg::PROD_W-1:0];
          end
          quot     <= {quot[sglr_pkg::RATIO_W-2:0], fits};
          dsh      <= dsh >> 1;
          step_cnt <= step_cnt + sglr_pkg::STEP_W'(1);
          if (step_cnt == sglr_pkg::STEP_W'(sglr_pkg::DIV_STEPS - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register. It keeps its contents while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      loss_ratio     <= quot;
      missed_count   <= missed_total;
      received_count <= received_total;
      first_seq      <= first_seq_reg;
      outcome        <= outcome_hold;
    end
  end

endmodule

// ----- hdl/sglr_checker.sv -----
`timescale 1ns / 1ps

module sglr_checker #(
  parameter int SEQ_WIDTH = sglr_pkg::SEQ_WIDTH_DEFAULT
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [sglr_pkg::RATIO_W-1:0] loss_ratio,
  input logic [sglr_pkg::COUNT_W-1:0] missed_count,
  input logic [sglr_pkg::COUNT_W-1:0] received_count,
  input logic [SEQ_WIDTH-1:0]         first_seq,
  input sglr_pkg::outcome_t           outcome
);

  // A stalled result stays in place until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(loss_ratio) &&
      $stable(missed_count) && $stable(received_count) &&
      $stable(first_seq) && $stable(outcome))
    else $error("stalled result changed");

  // The block is busy in the cycle after it takes a sequence number.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a second item without working on the first");

  // Missed packets never outnumber all considered packets.
  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> loss_ratio <= sglr_pkg::RATIO_SCALE)
    else $error("loss ratio above full scale");

  // Every result follows at least one counted receipt.
  a_received: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> received_count != '0)
    else $error("result with no received packet");

  // The first packet can leave no gap behind it.
  a_first_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == sglr_pkg::OUT_FIRST |->
      missed_count == '0 && loss_ratio == '0)
    else $error("first packet reported a loss");

endmodule

bind sequence_gap_loss_ratio sglr_checker #(.SEQ_WIDTH(SEQ_WIDTH)) u_sglr_checker (.*);

// ----- tb/sv/loss_ratio_checker.sv -----
`timescale 1ns / 1ps

module loss_ratio_checker
  import sglr_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [SEQ_WIDTH_DEFAULT-1:0]  seq_number,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [RATIO_W-1:0]            loss_ratio,
  input  logic [COUNT_W-1:0]            missed_count,
  input  logic [COUNT_W-1:0]            received_count,
  input  logic [SEQ_WIDTH_DEFAULT-1:0]  first_seq,
  input  outcome_t                      outcome,
  input  logic                          run_done,
  output int                            failures
);

  localparam int SEQ_W = SEQ_WIDTH_DEFAULT;
  localparam int SHOWN_FAILURES = 30;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [COUNT_W-1:0] missed;
    logic [COUNT_W-1:0] received;
    logic [SEQ_W-1:0]   first;
    outcome_t           kind;
  } loss_report_t;

  // Shadow copy of the block's tracking state.
  logic               have_first;
  logic [SEQ_W-1:0]   newest_seq;
  logic [SEQ_W-1:0]   opening_seq;
  logic [COUNT_W-1:0] missed_sum;
  logic [COUNT_W-1:0] received_sum;

  loss_report_t expected_reports[$];

  int reports_checked;
  int kind_tally[4];
  int peak_ratio;
  bit closed;

  initial begin
    have_first = 1'b0;
    newest_seq = '0;
    opening_seq = '0;
    missed_sum = '0;
    received_sum = '0;
    failures = 0;
    reports_checked = 0;
    peak_ratio = 0;
    closed = 1'b0;
    foreach (kind_tally[k]) kind_tally[k] = 0;
  end

  function automatic logic [COUNT_W-1:0] count_sat_add(logic [COUNT_W-1:0] base,
                                                       longint unsigned amount);
    longint unsigned sum;
    sum = longint'(base) + amount;
    return (sum > longint'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
  endfunction

  // Classifies one packet number, updates the shadow counters and forms the
  // report that the block has to give for it.
  task automatic account_packet(input logic [SEQ_W-1:0] seq, output loss_report_t rpt);
    longint unsigned total;
    longint unsigned scaled;
    if (!have_first) begin
      have_first = 1'b1;
      opening_seq = seq;
      newest_seq = seq;
      received_sum = count_sat_add(received_sum, 1);
      rpt.kind = OUT_FIRST;
    end else if (seq > newest_seq) begin
      missed_sum = count_sat_add(missed_sum, longint'(seq) - longint'(newest_seq) - 1);
      newest_seq = seq;
      received_sum = count_sat_add(received_sum, 1);
      rpt.kind = OUT_NEWER;
    end else if (seq == newest_seq) begin
      rpt.kind = OUT_DUPLICATE;
    end else begin
      rpt.kind = OUT_ORDER;
    end
    total = longint'(received_sum) + longint'(missed_sum);
    scaled = longint'(missed_sum) * longint'(RATIO_SCALE);
    rpt.ratio = (total != 0) ? RATIO_W'(scaled / total) : '0;
    rpt.missed = missed_sum;
    rpt.received = received_sum;
    rpt.first = opening_seq;
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (failures < SHOWN_FAILURES)
      $display("[%0t] MISMATCH at report %0d, %s: got %0d, expected %0d",
               $realtime, reports_checked, what, got, want);
    failures++;
  endtask

  always @(posedge clk) begin
    loss_report_t want;
    loss_report_t fresh;
    if (!rst) begin
      // Results are taken before the new input so that an unexpected result
      // can never pair up with the item arriving in the same cycle.
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("result with nothing outstanding", loss_ratio, 0);
        end else begin
          want = expected_reports.pop_front();
          if (loss_ratio !== want.ratio)
            report_mismatch("loss_ratio", loss_ratio, want.ratio);
          if (missed_count !== want.missed)
            report_mismatch("missed_count", missed_count, want.missed);
          if (received_count !== want.received)
            report_mismatch("received_count", received_count, want.received);
          if (first_seq !== want.first)
            report_mismatch("first_seq", first_seq, want.first);
          if (outcome !== want.kind)
            report_mismatch("outcome", outcome, want.kind);
          kind_tally[want.kind]++;
          if (int'(want.ratio) > peak_ratio) peak_ratio = want.ratio;
        end
        reports_checked++;
      end
      if (in_valid && !in_stall) begin
        account_packet(seq_number, fresh);
        expected_reports.push_back(fresh);
      end
      if (run_done && !closed) begin
        closed = 1'b1;
        if (expected_reports.size() != 0)
          report_mismatch("reports never delivered", 0, expected_reports.size());
        $display("Checked %0d loss reports: %0d first, %0d newer, %0d duplicate, %0d out of order.",
                 reports_checked, kind_tally[OUT_FIRST], kind_tally[OUT_NEWER],
                 kind_tally[OUT_DUPLICATE], kind_tally[OUT_ORDER]);
        $display("Final counts: missed %0d, received %0d, highest loss ratio %0d.",
                 missed_sum, received_sum, peak_ratio);
      end
    end
  end

endmodule

// ----- tb/sv/sequence_gap_loss_ratio_test.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the loss ratio block. The checker beside the block
// watches both channels, keeps its own account of the counters and compares
// every loss report; this module only feeds sequence numbers, paces the
// result side and decides pass or fail at the end.
module sequence_gap_loss_ratio_test;
  import sglr_pkg::*;

  localparam int SEQ_W = SEQ_WIDTH_DEFAULT;

  // Random numbers climb no higher than this, so the closing items can still
  // show the top of the number range as a newer packet.
  localparam int unsigned RANDOM_CEILING = 65000;
  localparam int RANDOM_ITEMS = 1930;

  // The sender pauses once until the block has drained, in the middle of the
  // random part; the receiver holds off once for a long stretch.
  localparam int DRAIN_AT_ITEM = 900;
  localparam int HOLD_AT_RESULT = 500;
  localparam int HOLD_CYCLES = 300;

  // A slow but correct run, with the block's own work on each item and the idle
  // time that both sides add on top of it, stays well inside the cycle limit.
  localparam int TAIL_CYCLES = 40;
  localparam longint CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [SEQ_W-1:0] seq_number = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [RATIO_W-1:0] loss_ratio;
  logic [COUNT_W-1:0] missed_count;
  logic [COUNT_W-1:0] received_count;
  logic [SEQ_W-1:0]   first_seq;
  outcome_t           outcome;

  logic run_done = 1'b0;
  int   failures;

  // Transfers on each channel, counted by the process that drives it.
  int items_sent = 0;
  int results_taken = 0;

  // Highest sequence number offered so far; it steers the random choices.
  int unsigned top_seq = 0;

  longint cycle_count = 0;

  always #5 clk = ~clk;

  sequence_gap_loss_ratio DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .seq_number     (seq_number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .loss_ratio     (loss_ratio),
    .missed_count   (missed_count),
    .received_count (received_count),
    .first_seq      (first_seq),
    .outcome        (outcome)
  );

  loss_ratio_checker checker_inst (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .seq_number     (seq_number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .loss_ratio     (loss_ratio),
    .missed_count   (missed_count),
    .received_count (received_count),
    .first_seq      (first_seq),
    .outcome        (outcome),
    .run_done       (run_done),
    .failures       (failures)
  );

  // Idle cycles before the next transfer. Every fifth window of 120 transfers
  // runs with no idling at all, so back-to-back traffic is covered too.
  function automatic int draw_wait(int transfer_index);
    if ((transfer_index / 120) % 5 == 2) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Size of the gap in front of a newer packet. Mostly none or short, with a
  // few long jumps so the numbers climb through the upper half of the range.
  function automatic int unsigned draw_jump();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    if (pick < 80) return $urandom_range(1, 20);
    if (pick < 97) return $urandom_range(21, 200);
    return $urandom_range(201, 1200);
  endfunction

  // Offers one sequence number after a random number of idle cycles and
  // returns at the edge where the transfer happens. Valid stays high into
  // the next call, which lowers it only when it means to idle.
  task automatic send_packet(input int unsigned value);
    int idle;
    idle = draw_wait(items_sent);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    seq_number <= SEQ_W'(value);
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
    if (value > top_seq) top_seq = value;
  endtask

  // Mostly well-formed traffic: newer numbers with small gaps, with repeats
  // and late arrivals mixed in, some of them far below the newest number.
  task automatic send_random_packet();
    int unsigned pick;
    int unsigned step;
    int unsigned value;
    pick = $urandom_range(0, 99);
    if (pick < 60 && top_seq < RANDOM_CEILING) begin
      step = 1 + draw_jump();
      value = (top_seq + step > RANDOM_CEILING) ? RANDOM_CEILING : top_seq + step;
    end else if (pick < 80 || top_seq == 0) begin
      value = top_seq;
    end else if (pick < 90) begin
      value = top_seq - $urandom_range(1, (top_seq < 5) ? top_seq : 5);
    end else begin
      value = $urandom_range(0, top_seq - 1);
    end
    send_packet(value);
  endtask

  // Stops offering until every result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_taken != items_sent);
  endtask

  // Result side: stalls for a drawn number of cycles before each result,
  // once for a long stretch so the block backs up into its input.
  initial begin : result_pacing
    int hold;
    @(posedge clk);
    forever begin
      hold = (results_taken == HOLD_AT_RESULT) ? HOLD_CYCLES : draw_wait(results_taken);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      results_taken++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d of %0d results back.",
               cycle_count, results_taken, items_sent);
      $display("sequence_gap_loss_ratio verification failed");
      $finish;
    end
  end

  initial begin : packet_source
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Opening sequence: the first packet at zero, a repeat of it, an
    // in-order successor, a one-packet gap, late arrivals just below and
    // at the bottom of the range, and a long jump that drives the ratio up.
    send_packet(0);
    send_packet(0);
    send_packet(1);
    send_packet(3);
    send_packet(2);
    send_packet(3);
    send_packet(0);
    send_packet(13);
    send_packet(14);
    send_packet(1000);
    send_packet(999);
    send_packet(1000);
    send_packet(1001);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_random_packet();
      if (n == DRAIN_AT_ITEM) drain_results();
    end

    // Closing sequence: the top of the number range arrives as a newer
    // packet, then repeats, then packets far below it arrive late.
    send_packet(65535);
    send_packet(65535);
    send_packet(0);
    send_packet(32768);
    send_packet(65534);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);

    if (failures == 0) begin
      $display("sequence_gap_loss_ratio verification clean");
    end else begin
      $display("%0d mismatches found.", failures);
      $display("sequence_gap_loss_ratio verification failed");
    end
    $finish;
  end

endmodule
